>>> rtl/cvfs_pkg.sv
// Shared types and constants for the cell voltage frame statistics block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package cvfs_pkg;

	localparam int CHANNELS_PER_CHIP = 12;
	localparam int LAYOUT_REGS       = 5;
	localparam int LAYOUT_W          = 12;
	localparam int CHIP_W            = 3;
	localparam int CHAN_W            = 4;
	localparam int VOLT_W            = 16;
	localparam int TOTAL_W           = 22;
	localparam int CELL_W            = 6;
	localparam int PADDR_W           = 5;
	localparam int PDATA_W           = 32;
	localparam int REG_IDX_W         = 3;

	localparam logic [LAYOUT_W-1:0] LAYOUT_RESET  = 12'd12;
	localparam logic [VOLT_W-1:0]   NOT_CONVERTED = 16'hFFFF;
	localparam logic [CHAN_W-1:0]   LAST_CHANNEL  = 4'd11;

	typedef struct packed {
		logic [CHIP_W-1:0] chip_index;
		logic [CHAN_W-1:0] channel;
		logic [VOLT_W-1:0] raw_voltage;
		logic              group_check_error;
		logic              frame_last;
	} item_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total_voltage;
		logic [VOLT_W-1:0]  max_voltage;
		logic [VOLT_W-1:0]  min_voltage;
		logic [CELL_W-1:0]  max_cell;
		logic [CELL_W-1:0]  min_cell;
		logic               frame_accepted;
	} result_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [VOLT_W-1:0]  maxv;
		logic [VOLT_W-1:0]  minv;
		logic [CELL_W-1:0]  max_cell;
		logic [CELL_W-1:0]  min_cell;
	} stats_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_WALK   = 4'b0010,
		ST_FLUSH  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	// A channel is a cell if it lies in the front block or in the rear block
	// that follows the skipped empty channels.
	function automatic logic channel_mapped(input logic [LAYOUT_W-1:0] layout,
			input logic [CHAN_W-1:0] ch);
		logic [5:0] front;
		logic [5:0] rear_lo;
		logic [5:0] rear_hi;
		logic [5:0] ch6;
		front   = {2'b00, layout[3:0]};
		rear_lo = front + {2'b00, layout[7:4]};
		rear_hi = rear_lo + {2'b00, layout[11:8]};
		ch6     = {2'b00, ch};
		return (ch6 < front) || ((ch6 >= rear_lo) && (ch6 < rear_hi));
	endfunction

endpackage

`default_nettype wire

>>> rtl/cvfs_store.sv
// Staging and held reading memories with registered reads.
// Held entries carry valid bits so that unwritten cells read as zero.
// Depends on cvfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cvfs_store #(
	parameter int DEPTH = 60,
	parameter int AW    = 6
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        stg_we,
	input  wire logic [AW-1:0]               stg_waddr,
	input  wire logic [cvfs_pkg::VOLT_W-1:0] stg_wdata,
	input  wire logic                        rd_en,
	input  wire logic [AW-1:0]               rd_addr,
	output logic      [cvfs_pkg::VOLT_W-1:0] stg_rdata,
	input  wire logic                        hld_we,
	input  wire logic [AW-1:0]               hld_waddr,
	input  wire logic [cvfs_pkg::VOLT_W-1:0] hld_wdata,
	output logic      [cvfs_pkg::VOLT_W-1:0] hld_rdata
);

	logic [cvfs_pkg::VOLT_W-1:0] stg_mem [DEPTH];
	logic [cvfs_pkg::VOLT_W-1:0] hld_mem [DEPTH];
	logic [DEPTH-1:0]            hvalid_q;
	logic [cvfs_pkg::VOLT_W-1:0] stg_rd_q;
	logic [cvfs_pkg::VOLT_W-1:0] hld_rd_q;
	logic                        hvalid_rd_q;

	always_ff @(posedge clk) begin
		if (stg_we) begin
			stg_mem[stg_waddr] <= stg_wdata;
		end
		if (rd_en) begin
			stg_rd_q <= stg_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (hld_we) begin
			hld_mem[hld_waddr] <= hld_wdata;
		end
		if (rd_en) begin
			hld_rd_q <= hld_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q    <= '0;
			hvalid_rd_q <= 1'b0;
		end else begin
			if (hld_we) begin
				hvalid_q[hld_waddr] <= 1'b1;
			end
			if (rd_en) begin
				hvalid_rd_q <= hvalid_q[rd_addr];
			end
		end
	end

	assign stg_rdata = stg_rd_q;
	assign hld_rdata = hvalid_rd_q ? hld_rd_q : '0;

endmodule

`default_nettype wire

>>> rtl/cvfs_stats.sv
// Shared accumulate and compare unit: one mapped cell per cycle updates
// the running total, maximum and minimum. Depends on cvfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cvfs_stats (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        clear,
	input  wire logic                        en,
	input  wire logic [cvfs_pkg::VOLT_W-1:0] value,
	output cvfs_pkg::stats_t                 stats
);

	cvfs_pkg::stats_t              acc_q;
	logic [cvfs_pkg::CELL_W-1:0]   flat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			flat_q <= '0;
		end else if (clear) begin
			acc_q  <= '0;
			flat_q <= '0;
		end else if (en) begin
			acc_q.total <= acc_q.total + {{(cvfs_pkg::TOTAL_W - cvfs_pkg::VOLT_W){1'b0}}, value};
			flat_q      <= flat_q + 1'b1;
			// The first mapped cell seeds both extremes at index zero.
			if (flat_q == '0) begin
				acc_q.maxv     <= value;
				acc_q.minv     <= value;
				acc_q.max_cell <= '0;
				acc_q.min_cell <= '0;
			end else begin
				if (value > acc_q.maxv) begin
					acc_q.maxv     <= value;
					acc_q.max_cell <= flat_q;
				end
				if (value < acc_q.minv) begin
					acc_q.minv     <= value;
					acc_q.min_cell <= flat_q;
				end
			end
		end
	end

	assign stats = acc_q;

endmodule

`default_nettype wire

>>> rtl/cell_voltage_frame_stats_core.sv
// Cell voltage frame statistics: top level with sequencer and register port.
// Depends on cvfs_pkg, cvfs_store and cvfs_stats.
//
// Readings arrive on the item channel (item_valid / item_stall / item), one
// transfer per cycle while the block is idle. Each in-range reading is written
// to a staging memory. The transfer with frame_last set closes the frame: the
// sequencer then walks all CHIPS*12 cells, one per cycle through the shared
// accumulate/compare unit, committing staged readings to the held memory (when
// the frame had no checksum error) and folding mapped cells into the statistics.
// A last item keeps the block in the walk, flush and finish states before its
// result is loaded into the output register, the walk length being set by the
// single read port of the cell memories. item_stall is high from the walk until
// the result is loaded. The result leaves on the result channel
// (result_valid / result_stall / result) from a register; while the receiver
// stalls, the block still accepts the readings of the next frame, and holds
// at the end of the next walk until the register is free.
// Reset clears held readings to zero, layouts to 12 and the error flag. The
// layout registers sit on an APB-style port at byte address 4*i.
`timescale 1ns / 1ps
`default_nettype none

module cell_voltage_frame_stats_core #(
	parameter int CHIPS = 5
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire cvfs_pkg::item_t              item,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output cvfs_pkg::result_t                 result,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [cvfs_pkg::PADDR_W-1:0] paddr,
	input  wire logic [cvfs_pkg::PDATA_W-1:0] pwdata,
	output logic      [cvfs_pkg::PDATA_W-1:0] prdata,
	output logic                              pready
);

	localparam int CELLS = CHIPS * cvfs_pkg::CHANNELS_PER_CHIP;
	localparam int AW    = $clog2(CELLS);
	localparam logic [cvfs_pkg::CHIP_W-1:0] LAST_CHIP = cvfs_pkg::CHIP_W'(CHIPS - 1);

	logic [cvfs_pkg::LAYOUT_W-1:0] layout_q [cvfs_pkg::LAYOUT_REGS];
	logic [cvfs_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          cfg_wr;

	cvfs_pkg::state_t              state_q;
	logic                          err_q;
	logic                          commit_q;
	logic [cvfs_pkg::CHIP_W-1:0]   chip_q;
	logic [cvfs_pkg::CHAN_W-1:0]   chan_q;
	logic [AW-1:0]                 addr_q;
	logic                          valid_s1;
	logic                          mapped_s1;
	logic [AW-1:0]                 addr_s1;
	cvfs_pkg::result_t             result_q;
	logic                          result_valid_q;

	logic                          accept;
	logic                          in_range;
	logic [5:0]                    stg_addr_full;
	logic                          walking;
	logic                          walk_done;
	logic                          load_result;
	logic                          stats_clear;
	logic [cvfs_pkg::VOLT_W-1:0]   stg_rdata;
	logic [cvfs_pkg::VOLT_W-1:0]   hld_rdata;
	logic                          take_staged;
	logic [cvfs_pkg::VOLT_W-1:0]   cell_value;
	logic                          hld_we;
	cvfs_pkg::stats_t              stats;

	// Register port.
	assign pready  = 1'b1;
	assign reg_idx = paddr[cvfs_pkg::PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cvfs_pkg::LAYOUT_REGS; i++) begin
				layout_q[i] <= cvfs_pkg::LAYOUT_RESET;
			end
		end else if (cfg_wr && (reg_idx < cvfs_pkg::REG_IDX_W'(cvfs_pkg::LAYOUT_REGS))) begin
			layout_q[reg_idx] <= pwdata[cvfs_pkg::LAYOUT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx < cvfs_pkg::REG_IDX_W'(cvfs_pkg::LAYOUT_REGS)) begin
			prdata = {{(cvfs_pkg::PDATA_W - cvfs_pkg::LAYOUT_W){1'b0}}, layout_q[reg_idx]};
		end
	end

	// Input side.
	assign item_stall    = (state_q != cvfs_pkg::ST_IDLE);
	assign accept        = item_valid && !item_stall;
	assign in_range      = (item.chip_index < cvfs_pkg::CHIP_W'(CHIPS))
			&& (item.channel < cvfs_pkg::CHAN_W'(cvfs_pkg::CHANNELS_PER_CHIP));
	// chip * 12 as two shifts.
	assign stg_addr_full = ({3'b000, item.chip_index} << 3) + ({3'b000, item.chip_index} << 2)
			+ {2'b00, item.channel};
	assign stats_clear   = accept && item.frame_last;

	assign walking   = (state_q == cvfs_pkg::ST_WALK);
	assign walk_done = walking && (chip_q == LAST_CHIP) && (chan_q == cvfs_pkg::LAST_CHANNEL);
	assign load_result = (state_q == cvfs_pkg::ST_FINISH) && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cvfs_pkg::ST_IDLE;
			err_q    <= 1'b0;
			commit_q <= 1'b0;
			chip_q   <= '0;
			chan_q   <= '0;
			addr_q   <= '0;
		end else begin
			unique case (state_q)
				cvfs_pkg::ST_IDLE: begin
					if (accept) begin
						if (item.frame_last) begin
							commit_q <= !(err_q || item.group_check_error);
							err_q    <= 1'b0;
							chip_q   <= '0;
							chan_q   <= '0;
							addr_q   <= '0;
							state_q  <= cvfs_pkg::ST_WALK;
						end else if (item.group_check_error) begin
							err_q <= 1'b1;
						end
					end
				end
				cvfs_pkg::ST_WALK: begin
					addr_q <= addr_q + 1'b1;
					if (chan_q == cvfs_pkg::LAST_CHANNEL) begin
						chan_q <= '0;
						chip_q <= chip_q + 1'b1;
					end else begin
						chan_q <= chan_q + 1'b1;
					end
					if (walk_done) begin
						state_q <= cvfs_pkg::ST_FLUSH;
					end
				end
				cvfs_pkg::ST_FLUSH: begin
					state_q <= cvfs_pkg::ST_FINISH;
				end
				cvfs_pkg::ST_FINISH: begin
					if (load_result) begin
						state_q <= cvfs_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= cvfs_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Stage 1: the cell being read, in step with the registered memory data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= walking;
		end
	end

	always_ff @(posedge clk) begin
		if (walking) begin
			addr_s1   <= addr_q;
			mapped_s1 <= cvfs_pkg::channel_mapped(layout_q[chip_q], chan_q);
		end
	end

	assign take_staged = commit_q && (stg_rdata != cvfs_pkg::NOT_CONVERTED);
	assign cell_value  = take_staged ? stg_rdata : hld_rdata;
	assign hld_we      = valid_s1 && take_staged;

	cvfs_store #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.stg_we   (accept && in_range),
		.stg_waddr(stg_addr_full[AW-1:0]),
		.stg_wdata(item.raw_voltage),
		.rd_en    (walking),
		.rd_addr  (addr_q),
		.stg_rdata(stg_rdata),
		.hld_we   (hld_we),
		.hld_waddr(addr_s1),
		.hld_wdata(cell_value),
		.hld_rdata(hld_rdata)
	);

	cvfs_stats u_stats (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (stats_clear),
		.en    (valid_s1 && mapped_s1),
		.value (cell_value),
		.stats (stats)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			result_q.total_voltage  <= stats.total;
			result_q.max_voltage    <= stats.maxv;
			result_q.min_voltage    <= stats.minv;
			result_q.max_cell       <= stats.max_cell;
			result_q.min_cell       <= stats.min_cell;
			result_q.frame_accepted <= commit_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A new result only appears after the walk has finished.
	assert property (@(posedge clk) disable iff (!arst_n)
			$rose(result_valid_q) |-> $past(state_q == cvfs_pkg::ST_FINISH))
		else $error("result appeared without a finished walk");

	// Memory read data is only consumed for cells issued during the walk.
	assert property (@(posedge clk) disable iff (!arst_n)
			valid_s1 |-> $past(state_q == cvfs_pkg::ST_WALK))
		else $error("stage 1 valid outside the walk");

	// Held readings change only for a committed frame.
	assert property (@(posedge clk) disable iff (!arst_n)
			hld_we |-> commit_q)
		else $error("held reading written for an uncommitted frame");

	// No walk may overwrite a result that the receiver has not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
			(result_valid_q && result_stall) |=> result_valid_q)
		else $error("pending result dropped");

endmodule

`default_nettype wire

>>> tb/sv/tb_cell_voltage_frame_stats_core.sv
// Self-checking testbench for cell_voltage_frame_stats_core: drives frames of cell readings
// and layout writes, predicts each frame's statistics and compares every result transfer.
// Depends on cvfs_pkg and the cell_voltage_frame_stats_core RTL.
`timescale 1ns / 1ps

module tb_cell_voltage_frame_stats_core;

	localparam int CHIPS        = 5;
	localparam int CELLS        = CHIPS * cvfs_pkg::CHANNELS_PER_CHIP;
	localparam int CLK_HALF     = 10;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int WALK_CYCLES  = CELLS + 2;
	localparam int SETTLE       = 4;
	localparam int LONG_HOLD    = 300;
	localparam int IDLE_PCT     = 13;
	localparam int REG_STRIDE   = 4;
	localparam int RANDOM_ITEMS = 1650;
	localparam logic [cvfs_pkg::LAYOUT_W-1:0] LAYOUT_NONE = '0;
	localparam logic [cvfs_pkg::LAYOUT_W-1:0] LAYOUT_ALL  = '1;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          item_valid   = 1'b0;
	logic                          item_stall;
	cvfs_pkg::item_t               item_bus     = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	cvfs_pkg::result_t             result_bus;
	logic                          psel         = 1'b0;
	logic                          penable      = 1'b0;
	logic                          pwrite       = 1'b0;
	logic [cvfs_pkg::PADDR_W-1:0]  paddr        = '0;
	logic [cvfs_pkg::PDATA_W-1:0]  pwdata       = '0;
	logic [cvfs_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;

	// Predictor state: its own copy of the staging store, held cells and layouts.
	logic [cvfs_pkg::VOLT_W-1:0]   staged_mv [CELLS] = '{default: '0};
	logic [cvfs_pkg::VOLT_W-1:0]   held_mv [CELLS]   = '{default: '0};
	logic [cvfs_pkg::LAYOUT_W-1:0] layout_cfg [cvfs_pkg::LAYOUT_REGS] =
			'{default: cvfs_pkg::LAYOUT_RESET};
	bit                            error_pending = 1'b0;

	cvfs_pkg::result_t             frame_stats_q [$];
	int                            fail_count    = 0;
	int                            items_sent    = 0;
	bit                            no_idle       = 1'b0;
	bit                            long_hold_req = 1'b0;
	int                            hold_left     = 0;

	cell_voltage_frame_stats_core #(.CHIPS(CHIPS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_bus),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	// Stages the reading and, on the last item of a frame, commits an error-free
	// frame and walks the mapped cells. Returns 1 when the item closes a frame.
	function automatic bit predict_frame_stats(input cvfs_pkg::item_t it,
			output cvfs_pkg::result_t stats);
		int          flat;
		int          v;
		int          front;
		int          gap_n;
		int          rear;
		int unsigned total;
		bit          accepted;
		stats = '0;
		flat  = 0;
		total = 0;
		if (it.chip_index < CHIPS && it.channel < cvfs_pkg::CHANNELS_PER_CHIP)
			staged_mv[it.chip_index * cvfs_pkg::CHANNELS_PER_CHIP + it.channel] = it.raw_voltage;
		if (it.group_check_error)
			error_pending = 1'b1;
		if (!it.frame_last)
			return 1'b0;
		accepted      = !error_pending;
		error_pending = 1'b0;
		if (accepted) begin
			for (int k = 0; k < CELLS; k++)
				if (staged_mv[k] != cvfs_pkg::NOT_CONVERTED)
					held_mv[k] = staged_mv[k];
		end
		for (int c = 0; c < CHIPS; c++) begin
			front = int'(layout_cfg[c][3:0]);
			gap_n = int'(layout_cfg[c][7:4]);
			rear  = int'(layout_cfg[c][11:8]);
			for (int k = 0; k < cvfs_pkg::CHANNELS_PER_CHIP; k++) begin
				if (k < front || (k >= front + gap_n && k < front + gap_n + rear)) begin
					v     = int'(held_mv[c * cvfs_pkg::CHANNELS_PER_CHIP + k]);
					total += v;
					if (flat == 0) begin
						stats.max_voltage = cvfs_pkg::VOLT_W'(v);
						stats.min_voltage = cvfs_pkg::VOLT_W'(v);
					end else begin
						// Strict compares keep the first occurrence on ties.
						if (v > stats.max_voltage) begin
							stats.max_voltage = cvfs_pkg::VOLT_W'(v);
							stats.max_cell    = cvfs_pkg::CELL_W'(flat);
						end
						if (v < stats.min_voltage) begin
							stats.min_voltage = cvfs_pkg::VOLT_W'(v);
							stats.min_cell    = cvfs_pkg::CELL_W'(flat);
						end
					end
					flat++;
				end
			end
		end
		stats.total_voltage  = total[cvfs_pkg::TOTAL_W-1:0];
		stats.frame_accepted = accepted;
		return 1'b1;
	endfunction

	function automatic cvfs_pkg::item_t mk_item(input int chip, input int ch, input int raw,
			input bit err, input bit last);
		cvfs_pkg::item_t it;
		it.chip_index        = cvfs_pkg::CHIP_W'(chip);
		it.channel           = cvfs_pkg::CHAN_W'(ch);
		it.raw_voltage       = cvfs_pkg::VOLT_W'(raw);
		it.group_check_error = err;
		it.frame_last        = last;
		return it;
	endfunction

	function automatic logic [cvfs_pkg::VOLT_W-1:0] pick_raw();
		case ($urandom_range(9, 0))
			0: return '0;
			1: return cvfs_pkg::NOT_CONVERTED;
			2: return cvfs_pkg::NOT_CONVERTED - 1'b1;
			// A few shared values make ties between cells likely.
			3: return cvfs_pkg::VOLT_W'(1000 * $urandom_range(3, 1));
			default: return cvfs_pkg::VOLT_W'($urandom_range(65535, 0));
		endcase
	endfunction

	function automatic logic [cvfs_pkg::LAYOUT_REGS*cvfs_pkg::LAYOUT_W-1:0] random_layouts();
		logic [cvfs_pkg::LAYOUT_REGS*cvfs_pkg::LAYOUT_W-1:0] all_layouts;
		for (int r = 0; r < cvfs_pkg::LAYOUT_REGS; r++) begin
			case ($urandom_range(5, 0))
				0: all_layouts[r*cvfs_pkg::LAYOUT_W +: cvfs_pkg::LAYOUT_W] = LAYOUT_NONE;
				1: all_layouts[r*cvfs_pkg::LAYOUT_W +: cvfs_pkg::LAYOUT_W] = LAYOUT_ALL;
				2: all_layouts[r*cvfs_pkg::LAYOUT_W +: cvfs_pkg::LAYOUT_W] =
						cvfs_pkg::LAYOUT_RESET;
				default: all_layouts[r*cvfs_pkg::LAYOUT_W +: cvfs_pkg::LAYOUT_W] =
						cvfs_pkg::LAYOUT_W'($urandom_range(4095, 0));
			endcase
		end
		return all_layouts;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic send_reading(input cvfs_pkg::item_t it);
		cvfs_pkg::result_t stats;
		while (!no_idle && $urandom_range(99, 0) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_bus   <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall !== 1'b0);
		items_sent++;
		if (predict_frame_stats(it, stats))
			frame_stats_q.push_back(stats);
	endtask

	task automatic wait_for_results(input int settle);
		item_valid <= 1'b0;
		while (frame_stats_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Write one layout register, then read it back.
	task automatic write_layout(input int r, input logic [cvfs_pkg::LAYOUT_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= cvfs_pkg::PADDR_W'(r * REG_STRIDE);
		pwdata  <= cvfs_pkg::PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		layout_cfg[r] = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		check_field($sformatf("chip%0d_layout", r), cvfs_pkg::PDATA_W'(value), prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reconfigure(
			input logic [cvfs_pkg::LAYOUT_REGS*cvfs_pkg::LAYOUT_W-1:0] all_layouts);
		wait_for_results(SETTLE);
		for (int r = 0; r < cvfs_pkg::LAYOUT_REGS; r++)
			write_layout(r, all_layouts[r*cvfs_pkg::LAYOUT_W +: cvfs_pkg::LAYOUT_W]);
	endtask

	task automatic send_random_frame(input int len, input bit spoil);
		int              err_at;
		cvfs_pkg::item_t it;
		err_at = spoil ? $urandom_range(len - 1, 0) : -1;
		for (int i = 0; i < len; i++) begin
			it.chip_index = cvfs_pkg::CHIP_W'(($urandom_range(99, 0) < 92)
				? $urandom_range(CHIPS - 1, 0) : $urandom_range(7, CHIPS));
			it.channel = cvfs_pkg::CHAN_W'(($urandom_range(99, 0) < 92)
				? $urandom_range(cvfs_pkg::CHANNELS_PER_CHIP - 1, 0)
				: $urandom_range(15, cvfs_pkg::CHANNELS_PER_CHIP));
			it.raw_voltage       = pick_raw();
			it.group_check_error = (i == err_at) || ($urandom_range(99, 0) < 2);
			it.frame_last        = (i == len - 1);
			send_reading(it);
		end
	endtask

	task automatic send_sweep_frame(input bit spoil);
		for (int idx = 0; idx < CELLS; idx++)
			send_reading(mk_item(idx / cvfs_pkg::CHANNELS_PER_CHIP,
				idx % cvfs_pkg::CHANNELS_PER_CHIP, int'(pick_raw()),
				spoil && idx == CELLS / 2, idx == CELLS - 1));
	endtask

	// An error frame under the reset layouts reports the cleared held cells.
	task automatic test_reset_state();
		send_reading(mk_item(0, 0, 16'h1234, 1'b1, 1'b1));
		wait_for_results(SETTLE);
	endtask

	// Every staging entry is written here before anything can be committed.
	// Cell 0 ties the last cell at the maximum and must win.
	task automatic test_first_commit();
		int raw;
		for (int idx = 0; idx < CELLS; idx++) begin
			raw = int'($urandom_range(int'(cvfs_pkg::NOT_CONVERTED) - 2, 1));
			if (idx == 0 || idx == CELLS - 1)
				raw = int'(cvfs_pkg::NOT_CONVERTED) - 1;
			else if (idx == 1)
				raw = 0;
			else if (idx == 5)
				raw = int'(cvfs_pkg::NOT_CONVERTED);
			send_reading(mk_item(idx / cvfs_pkg::CHANNELS_PER_CHIP,
				idx % cvfs_pkg::CHANNELS_PER_CHIP, raw, 1'b0, idx == CELLS - 1));
		end
		wait_for_results(SETTLE);
	endtask

	task automatic test_special_items();
		// Out-of-range chip and channel readings are dropped, but their flags act.
		send_reading(mk_item(7, 3, 16'h0055, 1'b0, 1'b0));
		send_reading(mk_item(2, 15, 16'hAAAA, 1'b0, 1'b0));
		send_reading(mk_item(CHIPS, cvfs_pkg::CHANNELS_PER_CHIP, 16'h00FF, 1'b0, 1'b1));
		send_reading(mk_item(6, 0, 16'h0000, 1'b1, 1'b0));
		send_reading(mk_item(0, 1, 16'd100, 1'b0, 1'b1));
		// The error flag cleared with the rejected frame, so this one commits.
		send_reading(mk_item(0, 1, 16'd100, 1'b0, 1'b1));
		send_reading(mk_item(1, 4, int'(cvfs_pkg::NOT_CONVERTED), 1'b0, 1'b1));
		send_reading(mk_item(4, 11, 16'd0, 1'b0, 1'b0));
		send_reading(mk_item(3, 2, int'(cvfs_pkg::NOT_CONVERTED) - 1, 1'b0, 1'b1));
		wait_for_results(SETTLE);
	endtask

	task automatic test_layout_extremes();
		reconfigure({cvfs_pkg::LAYOUT_REGS{LAYOUT_NONE}});
		send_reading(mk_item(0, 0, 16'd500, 1'b0, 1'b1));
		reconfigure({cvfs_pkg::LAYOUT_REGS{LAYOUT_ALL}});
		send_reading(mk_item(2, 7, 16'd501, 1'b0, 1'b1));
		reconfigure({cvfs_pkg::LAYOUT_REGS{12'hC00}});
		send_reading(mk_item(4, 0, 16'd502, 1'b0, 1'b1));
		// Rear blocks running past channel 11, a capped front count and an
		// empty gap that pushes the whole rear block off the chip.
		reconfigure({12'h5A7, LAYOUT_NONE, 12'h20F, 12'h0B1, 12'hF43});
		send_reading(mk_item(1, 0, 16'd503, 1'b0, 1'b0));
		send_reading(mk_item(0, 8, 16'd504, 1'b0, 1'b1));
		reconfigure({cvfs_pkg::LAYOUT_REGS{cvfs_pkg::LAYOUT_RESET}});
		send_reading(mk_item(3, 3, 16'd505, 1'b0, 1'b1));
		wait_for_results(SETTLE);
	endtask

	// The receiver holds off long enough for the block to fill and stall its
	// input; the sender then waits for every result before going on.
	task automatic test_backpressure();
		long_hold_req = 1'b1;
		for (int f = 0; f < 4; f++)
			send_random_frame(4, 1'b0);
		wait_for_results(SETTLE);
	endtask

	task automatic test_random_traffic(input int n_items);
		int start;
		int next_cfg;
		int sent;
		int shape;
		start    = items_sent;
		next_cfg = $urandom_range(250, 150);
		sent     = 0;
		while (sent < n_items) begin
			if (sent >= next_cfg) begin
				reconfigure(random_layouts());
				next_cfg = sent + $urandom_range(250, 150);
			end
			no_idle = (sent >= 400 && sent < 700);
			shape   = $urandom_range(99, 0);
			if (shape < 4)
				send_sweep_frame($urandom_range(99, 0) < 10);
			else if (shape < 20)
				send_random_frame($urandom_range(20, 7), $urandom_range(99, 0) < 12);
			else
				send_random_frame($urandom_range(6, 1), $urandom_range(99, 0) < 12);
			sent = items_sent - start;
		end
		no_idle = 1'b0;
	endtask

	always @(posedge clk) begin
		if (long_hold_req) begin
			hold_left     = LONG_HOLD;
			long_hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !no_idle && ($urandom_range(99, 0) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cvfs_pkg::result_t want;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (frame_stats_q.size() == 0) begin
				$error("result transfer with nothing expected: %p", result_bus);
				fail_count++;
			end else begin
				want = frame_stats_q.pop_front();
				check_field("total_voltage", 32'(want.total_voltage),
					32'(result_bus.total_voltage));
				check_field("max_voltage", 32'(want.max_voltage), 32'(result_bus.max_voltage));
				check_field("min_voltage", 32'(want.min_voltage), 32'(result_bus.min_voltage));
				check_field("max_cell", 32'(want.max_cell), 32'(result_bus.max_cell));
				check_field("min_cell", 32'(want.min_cell), 32'(result_bus.min_cell));
				check_field("frame_accepted", 32'(want.frame_accepted),
					32'(result_bus.frame_accepted));
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_first_commit();
		test_special_items();
		test_layout_extremes();
		test_backpressure();
		test_random_traffic(RANDOM_ITEMS);
		wait_for_results(WALK_CYCLES + 8);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
